@@ src/dbd_pkg.sv @@
// Package for the detection box decoder: configuration and job types, register
// indexes and the corner arithmetic shared by the row tracker and the corner pipe.
// No dependencies.
`default_nettype none

package dbd_pkg;

    // Largest class count honored, whatever the register holds.
    localparam int unsigned MAX_CLASSES = 256;

    localparam int unsigned NUM_W   = 35;  // center +/- size/2 - pad, Q.17
    localparam int unsigned PROD_W  = 60;  // NUM_W times unsigned Q8.16
    localparam int unsigned COORD_W = 29;
    localparam int unsigned SCORE_W = 31;
    localparam int unsigned CLASS_W = 8;
    localparam int unsigned OUT_W   = 160;

    typedef enum logic [2:0] {
        REG_MIN_SCORE       = 3'd0,
        REG_CLASS_COUNT     = 3'd1,
        REG_BOX_LIMIT       = 3'd2,
        REG_PAD_LEFT        = 3'd3,
        REG_PAD_TOP         = 3'd4,
        REG_INVERSE_SCALE   = 3'd5,
        REG_IMAGE_WIDTH     = 3'd6,
        REG_IMAGE_HEIGHT    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [16:0] min_score;
        logic [8:0]  class_count;
        logic [15:0] box_limit;
        logic [11:0] pad_left;
        logic [11:0] pad_top;
        logic [23:0] inverse_scale;
        logic [13:0] image_width;
        logic [13:0] image_height;
    } cfg_t;

    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Corner order everywhere: left, top, right, bottom.
    typedef struct packed {
        num_t [3:0]         num;
        logic [SCORE_W-1:0] best_score;
        logic [CLASS_W-1:0] best_class;
    } job_t;

    // Class count as used: zero reads as one, large values are cut.
    function automatic logic [8:0] effective_classes(input logic [8:0] count);
        logic [8:0] eff;
        if (count == 9'd0) begin
            eff = 9'd1;
        end else if (32'(count) > MAX_CLASSES) begin
            eff = 9'(MAX_CLASSES);
        end else begin
            eff = count;
        end
        return eff;
    endfunction

    // The corner coordinate minus the padding in Q.17, which is twice it in Q16.16.
    function automatic num_t corner_num(input logic signed [31:0] center,
                                        input logic signed [31:0] size,
                                        input logic               subtract,
                                        input logic [11:0]        pad);
        num_t c2;
        num_t s;
        num_t p;
        c2 = {{2{center[31]}}, center, 1'b0};
        s  = {{3{size[31]}}, size};
        p  = {6'd0, pad, 17'd0};
        return subtract ? (c2 - s - p) : (c2 + s - p);
    endfunction

    // Upper clamp for one axis: (dimension - 1) in Q16.16, dimension capped at 8192.
    function automatic logic [COORD_W-1:0] axis_limit(input logic [13:0] dim);
        logic [13:0] d;
        logic [12:0] dm1;
        d   = (dim > 14'd8192) ? 14'd8192 : dim;
        dm1 = 13'(d - 14'd1);
        return (d == 14'd0) ? '0 : {dm1, 16'd0};
    endfunction

    // Round the Q.33 product half up to Q16.16, clamp to lim; non-positive is zero.
    function automatic logic [COORD_W-1:0] corner_out(input prod_t              prod,
                                                      input logic [COORD_W-1:0] lim);
        logic [PROD_W-1:0] sum;
        logic [42:0]       r;
        logic [COORD_W-1:0] res;
        sum = {1'b0, prod[PROD_W-2:0]} + PROD_W'(17'h10000);
        r   = sum[59:17];
        if (prod[PROD_W-1] || prod == '0) begin
            res = '0;
        end else if (r > {14'd0, lim}) begin
            res = lim;
        end else begin
            res = r[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ src/dbd_row_track.sv @@
// Row tracker for the detection box decoder: word position, box words, running
// class maximum and per-frame box count; issues one job per kept row. Uses dbd_pkg.
`default_nettype none

module dbd_row_track (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dbd_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   in_word,
    input  wire logic          in_frame_start,
    output logic               job_valid,
    input  wire logic          job_ready,
    output dbd_pkg::job_t      job
);
    import dbd_pkg::*;

    logic [8:0]          pos_reg, pos_next;
    logic signed [31:0]  box_reg [4];
    logic [SCORE_W-1:0]  best_reg, best_next;
    logic [CLASS_W-1:0]  class_reg, class_next;
    logic [15:0]         count_reg, count_next;
    logic                job_v_reg, job_v_next;
    job_t                job_reg, job_next;

    logic                accept;
    logic [8:0]          last_pos;
    logic [8:0]          pos_cur;
    logic [CLASS_W-1:0]  class_pos;
    logic [15:0]         count_cur;
    logic                box_word;
    logic                take;
    logic [SCORE_W-1:0]  best_new;
    logic [CLASS_W-1:0]  class_new;
    logic                row_end;
    logic                keep;

    assign in_ready  = !job_v_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = job_v_reg;
    assign job       = job_reg;

    always_comb begin
        last_pos  = 9'd3 + effective_classes(cfg.class_count);
        pos_cur   = in_frame_start ? 9'd0 : pos_reg;
        count_cur = in_frame_start ? 16'd0 : count_reg;
        box_word  = (pos_cur[8:2] == 7'd0);
        class_pos = CLASS_W'(pos_cur - 9'd4);

        take      = !in_word[31] && (in_word[30:0] > best_reg);
        best_new  = take ? in_word[30:0] : best_reg;
        class_new = take ? class_pos : class_reg;

        row_end = !box_word && (pos_cur >= last_pos);
        keep    = row_end && (best_new >= {14'd0, cfg.min_score})
                  && (count_cur < cfg.box_limit);

        if (box_word) begin
            pos_next   = pos_cur + 9'd1;
            best_next  = (pos_cur == 9'd0) ? '0 : best_reg;
            class_next = (pos_cur == 9'd0) ? '0 : class_reg;
        end else begin
            pos_next   = row_end ? 9'd0 : pos_cur + 9'd1;
            best_next  = best_new;
            class_next = class_new;
        end
        count_next = keep ? count_cur + 16'd1 : count_cur;

        if (accept && keep) begin
            job_v_next = 1'b1;
        end else if (job_ready) begin
            job_v_next = 1'b0;
        end else begin
            job_v_next = job_v_reg;
        end

        job_next.num[0]     = corner_num(box_reg[0], box_reg[2], 1'b1, cfg.pad_left);
        job_next.num[1]     = corner_num(box_reg[1], box_reg[3], 1'b1, cfg.pad_top);
        job_next.num[2]     = corner_num(box_reg[0], box_reg[2], 1'b0, cfg.pad_left);
        job_next.num[3]     = corner_num(box_reg[1], box_reg[3], 1'b0, cfg.pad_top);
        job_next.best_score = best_new;
        job_next.best_class = class_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            best_reg  <= '0;
            class_reg <= '0;
            count_reg <= '0;
            job_v_reg <= 1'b0;
        end else begin
            job_v_reg <= job_v_next;
            if (accept) begin
                pos_reg   <= pos_next;
                best_reg  <= best_next;
                class_reg <= class_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && box_word) begin
            box_reg[pos_cur[1:0]] <= $signed(in_word);
        end
        if (accept && keep) begin
            job_reg <= job_next;
        end
    end

endmodule

`default_nettype wire

@@ src/dbd_corner_pipe.sv @@
// Corner pipe for the detection box decoder: scale multiply stage, then rounding,
// clamping and the output register with its stream handshake. Uses dbd_pkg.
`default_nettype none

module dbd_corner_pipe (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire dbd_pkg::cfg_t cfg,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire dbd_pkg::job_t job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [159:0]       out_data
);
    import dbd_pkg::*;

    logic                mul_v_reg;
    prod_t               prod_reg [4];
    logic [SCORE_W-1:0]  mul_score_reg;
    logic [CLASS_W-1:0]  mul_class_reg;
    logic                out_v_reg;
    logic [OUT_W-1:0]    out_reg, out_next;

    logic                out_free;
    logic                mul_free;
    logic signed [24:0]  scale;
    logic [COORD_W-1:0]  lim_x, lim_y;
    logic [COORD_W-1:0]  corner [4];

    assign out_free  = !out_v_reg || out_ready;
    assign mul_free  = !mul_v_reg || out_free;
    assign job_ready = mul_free;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;
    assign scale     = {1'b0, cfg.inverse_scale};

    always_comb begin
        lim_x     = axis_limit(cfg.image_width);
        lim_y     = axis_limit(cfg.image_height);
        corner[0] = corner_out(prod_reg[0], lim_x);
        corner[1] = corner_out(prod_reg[1], lim_y);
        corner[2] = corner_out(prod_reg[2], lim_x);
        corner[3] = corner_out(prod_reg[3], lim_y);
        out_next  = {5'd0, mul_class_reg, mul_score_reg,
                     corner[3], corner[2], corner[1], corner[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (mul_free) begin
                mul_v_reg <= job_valid;
            end
            if (out_free) begin
                out_v_reg <= mul_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_free && job_valid) begin
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= $signed(job.num[i]) * scale;
            end
            mul_score_reg <= job.best_score;
            mul_class_reg <= job.best_class;
        end
        if (out_free && mul_v_reg) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

@@ src/detection_box_decode.sv @@
// Top level of the detection box decoder: configuration registers, the row
// tracker and the corner pipe. Uses dbd_pkg, dbd_row_track and dbd_corner_pipe.
//
// Usage: the detector's output tensor arrives on the s_ stream, one signed
// Q16.16 word per beat. Each row is four box words (center x, center y,
// width, height) followed by class_count score words. s_tuser marks the
// first word of a frame; it restarts the row and clears the box count.
// At the last word of a row whose best score reaches the threshold, and
// while fewer than box_limit boxes have gone out in this frame, one beat
// leaves on the m_ stream with the clamped corners, the score and class.
// Throughput is one word per cycle while s_tready is high; the row position
// wraps to zero in the same cycle in which a row's last word is taken, so
// rows follow each other without a gap. A kept row's box passes through the
// job register, the register after the four corner multipliers, and the
// result register, which holds the rounded and clamped corners and drives
// m_tvalid.
// When the receiver stalls, the result register and the two stages before
// it fill; s_tready then stays low while the job register holds a box that
// the corner pipe cannot take, that is once three boxes are waiting.
// Reset (aresetn, synchronous, active low) empties the pipe, clears the row
// position, running maximum and box count, and loads the register defaults.
// Write the configuration port only while no row is in flight (unchecked).
`default_nettype none

module detection_box_decode (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] row_word
    input  wire logic [0:0]   s_tuser,   // [0] frame_start
    // Result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,   // [28:0] left, [57:29] top, [86:58] right,
                                         // [115:87] bottom, [146:116] best_score,
                                         // [154:147] best_class, rest zero
    // Configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [23:0]  cfg_wdata
);
    import dbd_pkg::*;

    cfg_t cfg_reg;
    logic job_valid;
    logic job_ready;
    job_t job;

    // Register writes; widths are cut to each register's own size.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_score       <= 17'd16384;
            cfg_reg.class_count     <= 9'd80;
            cfg_reg.box_limit       <= 16'd30000;
            cfg_reg.pad_left        <= 12'd0;
            cfg_reg.pad_top         <= 12'd0;
            cfg_reg.inverse_scale   <= 24'd65536;
            cfg_reg.image_width     <= 14'd640;
            cfg_reg.image_height    <= 14'd640;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_addr))
                REG_MIN_SCORE:       cfg_reg.min_score       <= cfg_wdata[16:0];
                REG_CLASS_COUNT:     cfg_reg.class_count     <= cfg_wdata[8:0];
                REG_BOX_LIMIT:       cfg_reg.box_limit       <= cfg_wdata[15:0];
                REG_PAD_LEFT:        cfg_reg.pad_left        <= cfg_wdata[11:0];
                REG_PAD_TOP:         cfg_reg.pad_top         <= cfg_wdata[11:0];
                REG_INVERSE_SCALE:   cfg_reg.inverse_scale   <= cfg_wdata;
                REG_IMAGE_WIDTH:     cfg_reg.image_width     <= cfg_wdata[13:0];
                REG_IMAGE_HEIGHT:    cfg_reg.image_height    <= cfg_wdata[13:0];
                default: ;
            endcase
        end
    end

    // Position, box words and the class maximum; one job per kept row.
    dbd_row_track u_row_track (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_word        (s_tdata),
        .in_frame_start (s_tuser[0]),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job            (job)
    );

    // Scale, round and clamp the four corners, then hold the result beat.
    dbd_corner_pipe u_corner_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
